// File: design/pcx_rle_pkg.sv
// Shared types and constants for the PCX run-length line decoder.
// No dependencies; used by every module of the decoder.
`default_nettype none

package pcx_rle_pkg;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_LINE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PIXELS   = 2'd3;

	localparam logic [7:0] MARKER_MASK = 8'hC0;
	localparam logic [7:0] RUN_MASK    = 8'h3F;

	localparam logic [1:0] PIX_ONE = 2'd1;
	localparam logic [1:0] PIX_TWO = 2'd2;

	localparam logic        PIXEL_MODE_RST     = 1'b0;
	localparam logic [15:0] BYTES_PER_LINE_RST = 16'd1;
	localparam logic [15:0] LINE_WIDTH_RST     = 16'd1;
	localparam logic [23:0] TOTAL_PIXELS_RST   = 24'd1;

	// Command queue between the byte classifier and the run expander.
	localparam int unsigned CMD_Q_DEPTH = 2;
	localparam int unsigned CMD_Q_PTR_W = $clog2(CMD_Q_DEPTH);
	localparam int unsigned CMD_Q_CNT_W = $clog2(CMD_Q_DEPTH + 1);

	typedef struct packed {
		logic        pixel_mode;
		logic [15:0] bytes_per_line;
		logic [15:0] line_width;
	} cfg_t;

	typedef struct packed {
		logic        load;
		logic [23:0] total;
	} restart_t;

	typedef struct packed {
		logic [7:0] value;
		logic [5:0] runs;
	} cmd_t;

	typedef struct packed {
		logic [3:0] first;
		logic [3:0] second;
		logic [1:0] count;
		logic       run_last;
		logic       done;
	} res_t;

endpackage

`default_nettype wire

// File: design/pcx_rle_front.sv
// Byte classifier: splits the encoded stream into literal and run commands.
// Depends on pcx_rle_pkg for the command type and marker constants.
`default_nettype none

module pcx_rle_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              restart,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        code_byte,
	input  wire logic              q_full,
	output logic                   push,
	output pcx_rle_pkg::cmd_t      push_cmd
);

	logic       await_q;
	logic [5:0] count_q;
	logic       fire;
	logic       marker;

	assign in_ready = !q_full;
	assign fire     = in_valid && in_ready;
	assign marker   = (code_byte & pcx_rle_pkg::MARKER_MASK) == pcx_rle_pkg::MARKER_MASK;

	// A run with a zero count is consumed here and never reaches the expander.
	always_comb begin
		push_cmd.value = code_byte;
		push_cmd.runs  = await_q ? count_q : 6'd1;
		push = fire && (await_q || !marker) && (push_cmd.runs != 6'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_q <= 1'b0;
			count_q <= 6'd0;
		end else if (restart) begin
			await_q <= 1'b0;
			count_q <= 6'd0;
		end else if (fire) begin
			if (await_q) begin
				await_q <= 1'b0;
				count_q <= 6'd0;
			end else if (marker) begin
				await_q <= 1'b1;
				count_q <= code_byte[5:0] & pcx_rle_pkg::RUN_MASK[5:0];
			end
		end
	end

endmodule

`default_nettype wire

// File: design/pcx_rle_queue.sv
// Short command queue between the classifier and the run expander.
// Depends on pcx_rle_pkg for the command type and queue depth.
`default_nettype none

module pcx_rle_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire pcx_rle_pkg::cmd_t push_cmd,
	output logic                   full,
	input  wire logic              pop,
	output logic                   head_valid,
	output pcx_rle_pkg::cmd_t      head
);

	localparam int unsigned DEPTH = pcx_rle_pkg::CMD_Q_DEPTH;
	localparam int unsigned PTR_W = pcx_rle_pkg::CMD_Q_PTR_W;
	localparam int unsigned CNT_W = pcx_rle_pkg::CMD_Q_CNT_W;

	pcx_rle_pkg::cmd_t entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full       = cnt_q == CNT_W'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: design/pcx_rle_back.sv
// Run expander: walks queued commands one decoded byte per cycle unless stalled,
// tracks the line position and the pixel budget, and drives the output register.
// Depends on pcx_rle_pkg for the config, command and result types.
`default_nettype none

module pcx_rle_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pcx_rle_pkg::cfg_t     cfg,
	input  wire pcx_rle_pkg::restart_t restart,
	input  wire logic                  head_valid,
	input  wire pcx_rle_pkg::cmd_t     head,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output pcx_rle_pkg::res_t          out_res
);

	logic [5:0]        iter_q;
	logic [15:0]       line_idx_q;
	logic [23:0]       pix_left_q;
	logic              finished_q;
	logic              hold_valid_q;
	pcx_rle_pkg::res_t hold_q;
	logic              out_valid_q;
	pcx_rle_pkg::res_t out_q;

	logic              keep;
	logic [15:0]       idx_inc;
	logic [15:0]       idx_next;
	logic [1:0]        cnt;
	logic [23:0]       pix_next;
	logic              img_end;
	logic [5:0]        iter_inc;
	logic              run_end;
	logic              out_free;
	logic              hold_avail;
	logic              step;
	logic              take;
	logic              move_hold;
	pcx_rle_pkg::res_t new_res;

	always_comb begin
		keep     = line_idx_q < cfg.line_width;
		idx_inc  = line_idx_q + 16'd1;
		idx_next = (idx_inc == 16'd0 || idx_inc >= cfg.bytes_per_line) ? 16'd0 : idx_inc;
		cnt      = (cfg.pixel_mode && pix_left_q[23:1] != 23'd0) ?
			pcx_rle_pkg::PIX_TWO : pcx_rle_pkg::PIX_ONE;
		pix_next = pix_left_q - {22'd0, cnt};
		img_end  = pix_next == 24'd0;
		iter_inc = iter_q + 6'd1;
		run_end  = (iter_inc == head.runs) || (keep && img_end);

		out_free   = !out_valid_q || out_ready;
		hold_avail = !hold_valid_q || out_free;
		step       = head_valid && !finished_q && (!keep || hold_avail);
		take       = step && keep;
		// The held result leaves once its run is over or a newer kept result replaces it.
		move_hold  = hold_valid_q && out_free && (hold_q.run_last || take);
		pop        = (step && run_end) || (head_valid && finished_q);

		new_res.first    = cfg.pixel_mode ? head.value[7:4] : head.value[3:0];
		new_res.second   = (cnt == pcx_rle_pkg::PIX_TWO) ? head.value[3:0] : 4'd0;
		new_res.count    = cnt;
		new_res.run_last = run_end;
		new_res.done     = img_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q     <= 6'd0;
			line_idx_q <= 16'd0;
			pix_left_q <= pcx_rle_pkg::TOTAL_PIXELS_RST;
			finished_q <= 1'b0;
		end else if (restart.load) begin
			iter_q     <= 6'd0;
			line_idx_q <= 16'd0;
			pix_left_q <= restart.total;
			finished_q <= restart.total == 24'd0;
		end else if (step) begin
			line_idx_q <= idx_next;
			iter_q     <= run_end ? 6'd0 : iter_inc;
			if (keep) begin
				pix_left_q <= pix_next;
				finished_q <= img_end;
			end
		end else if (pop) begin
			iter_q <= 6'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (take) begin
				hold_valid_q <= 1'b1;
			end else if (move_hold) begin
				hold_valid_q <= 1'b0;
			end
			if (move_hold) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A run that ends on dropped padding bytes still closes its last kept result.
	always_ff @(posedge clk) begin
		if (take) begin
			hold_q <= new_res;
		end else if (step && run_end && hold_valid_q && !move_hold) begin
			hold_q.run_last <= 1'b1;
		end
		if (move_hold) begin
			out_q <= hold_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

`default_nettype wire

// File: design/pcx_rle_line_decoder_top.sv
// Top level of the PCX run-length line decoder: configuration registers,
// byte classifier, command queue and run expander. Depends on pcx_rle_pkg.
`default_nettype none

// The decoder takes one encoded byte per transfer and returns decoded pixels,
// one result per kept decoded byte. A literal byte sustains one byte per
// cycle while the output is not stalled, passing through the command queue,
// the hold register and the output register. A repeat marker yields nothing;
// its value byte occupies the run expander for one decoded byte per repeat
// (up to 63), including bytes that fall into line padding. The expander
// handles one decoded byte per cycle unless the output backs up; it sets the
// rate, and a two-entry command queue lets input keep flowing while it works.
// Configuration must be written only while the decoder is idle. Writing
// total_pixels starts a new image; the other registers take effect at once.
module pcx_rle_line_decoder_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [pcx_rle_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pcx_rle_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [7:0]                          code_byte,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [3:0]                               pixel_first,
	output logic [3:0]                               pixel_second,
	output logic [1:0]                               pixel_count,
	output logic                                     run_last,
	output logic                                     image_done
);

	pcx_rle_pkg::cfg_t     cfg_q;
	pcx_rle_pkg::restart_t restart;
	pcx_rle_pkg::cmd_t     push_cmd;
	pcx_rle_pkg::cmd_t     head;
	pcx_rle_pkg::res_t     out_res;
	logic                  push;
	logic                  q_full;
	logic                  pop;
	logic                  head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_mode     <= pcx_rle_pkg::PIXEL_MODE_RST;
			cfg_q.bytes_per_line <= pcx_rle_pkg::BYTES_PER_LINE_RST;
			cfg_q.line_width     <= pcx_rle_pkg::LINE_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pcx_rle_pkg::REG_PIXEL_MODE:     cfg_q.pixel_mode     <= cfg_data[0];
				pcx_rle_pkg::REG_BYTES_PER_LINE: cfg_q.bytes_per_line <= cfg_data[15:0];
				pcx_rle_pkg::REG_LINE_WIDTH:     cfg_q.line_width     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// The pixel total is consumed at the write itself by loading the budget.
	assign restart.load  = cfg_we && (cfg_index == pcx_rle_pkg::REG_TOTAL_PIXELS);
	assign restart.total = cfg_data[23:0];

	pcx_rle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart.load),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.code_byte(code_byte),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	pcx_rle_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	pcx_rle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.restart   (restart),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign pixel_first  = out_res.first;
	assign pixel_second = out_res.second;
	assign pixel_count  = out_res.count;
	assign run_last     = out_res.run_last;
	assign image_done   = out_res.done;

`ifndef SYNTHESIS
	// The result that exhausts the image always closes its run.
	a_done_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && image_done) |-> run_last)
		else $error("image_done without run_last");

	a_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel_count == pcx_rle_pkg::PIX_ONE ||
			pixel_count == pcx_rle_pkg::PIX_TWO))
		else $error("pixel_count out of range");

	a_second_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pixel_count == pcx_rle_pkg::PIX_ONE) |-> (pixel_second == 4'd0))
		else $error("pixel_second set on a single-pixel result");

	a_mode0_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !cfg_q.pixel_mode) |-> (pixel_count == pcx_rle_pkg::PIX_ONE))
		else $error("two pixels in one-pixel mode");
`endif

endmodule

`default_nettype wire

// File: verif/pcx_rle_line_decoder_top_tb.sv
// Self-checking testbench for pcx_rle_line_decoder_top: a scoreboard class predicts the
// decoded pixels of every accepted code byte and checks each pixel transfer in order.
// Depends on pcx_rle_pkg and pcx_rle_line_decoder_top.
module pcx_rle_line_decoder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT   = 300000;
	// Up to two queued runs of 63 bytes may fall into padding and yield nothing;
	// the rest is margin.
	localparam int unsigned SETTLE_CYCLES = 3 * 63 + 20;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned PHASE_ITEMS   = 13;
	localparam int unsigned RANDOM_PHASES = 6;
	localparam int unsigned MAX_REPORTS   = 10;

	class pixel_scoreboard;
		logic                      mode;
		logic [15:0]               bytes_per_line;
		logic [15:0]               line_width;
		logic [23:0]               total_pixels;
		logic                      await_value;
		logic [5:0]                repeat_count;
		logic [15:0]               line_idx;
		logic [24:0]               pixels_left;
		logic                      finished;
		pcx_rle_pkg::res_t         pixel_queue[$];
		int unsigned               errors;

		function new();
			mode           = pcx_rle_pkg::PIXEL_MODE_RST;
			bytes_per_line = pcx_rle_pkg::BYTES_PER_LINE_RST;
			line_width     = pcx_rle_pkg::LINE_WIDTH_RST;
			total_pixels   = pcx_rle_pkg::TOTAL_PIXELS_RST;
			errors         = 0;
			restart_image();
		endfunction

		function void restart_image();
			await_value  = 1'b0;
			repeat_count = '0;
			line_idx     = '0;
			pixels_left  = {1'b0, total_pixels};
			finished     = (total_pixels == '0);
		endfunction

		function void write_reg(logic [pcx_rle_pkg::CFG_IDX_W-1:0] idx,
			logic [pcx_rle_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				pcx_rle_pkg::REG_PIXEL_MODE: begin
					mode = val[0];
				end
				pcx_rle_pkg::REG_BYTES_PER_LINE: begin
					bytes_per_line = val[15:0];
				end
				pcx_rle_pkg::REG_LINE_WIDTH: begin
					line_width = val[15:0];
				end
				pcx_rle_pkg::REG_TOTAL_PIXELS: begin
					total_pixels = val;
					restart_image();
				end
				default: begin
				end
			endcase
		endfunction

		// Expands one accepted code byte into the pixel transfers it should cause.
		function void note_byte(logic [7:0] code);
			logic [5:0]        runs;
			logic              keep;
			logic [15:0]       next_idx;
			pcx_rle_pkg::res_t r;
			int                made;
			made = 0;
			if (finished)
				return;
			if (await_value) begin
				await_value  = 1'b0;
				runs         = repeat_count;
				repeat_count = '0;
			end else if ((code & pcx_rle_pkg::MARKER_MASK) == pcx_rle_pkg::MARKER_MASK) begin
				await_value  = 1'b1;
				repeat_count = code[5:0] & pcx_rle_pkg::RUN_MASK[5:0];
				return;
			end else begin
				runs = 6'd1;
			end
			for (int i = 0; i < int'(runs) && !finished; i++) begin
				keep     = line_idx < line_width;
				next_idx = line_idx + 16'd1;
				if (next_idx >= bytes_per_line || next_idx == '0)
					next_idx = '0;
				line_idx = next_idx;
				if (keep) begin
					if (mode) begin
						r.count  = (pixels_left >= 25'd2) ?
							pcx_rle_pkg::PIX_TWO : pcx_rle_pkg::PIX_ONE;
						r.first  = code[7:4];
						r.second = (r.count == pcx_rle_pkg::PIX_TWO) ? code[3:0] : 4'd0;
					end else begin
						r.count  = pcx_rle_pkg::PIX_ONE;
						r.first  = code[3:0];
						r.second = 4'd0;
					end
					pixels_left = pixels_left - {23'd0, r.count};
					if (pixels_left == '0)
						finished = 1'b1;
					r.run_last = 1'b0;
					r.done     = finished;
					pixel_queue.push_back(r);
					made++;
				end
			end
			if (made > 0) begin
				r = pixel_queue.pop_back();
				r.run_last = 1'b1;
				pixel_queue.push_back(r);
			end
		endfunction

		function string describe(pcx_rle_pkg::res_t r);
			return $sformatf("first=%0d second=%0d count=%0d last=%0d done=%0d",
				r.first, r.second, r.count, r.run_last, r.done);
		endfunction

		function void flag(string what, pcx_rle_pkg::res_t want, pcx_rle_pkg::res_t got);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t %s: expected %s, got %s", $time, what,
					describe(want), describe(got));
		endfunction

		function void check_result(pcx_rle_pkg::res_t got);
			pcx_rle_pkg::res_t want;
			if (pixel_queue.size() == 0) begin
				flag("unexpected pixel transfer", '0, got);
				return;
			end
			want = pixel_queue.pop_front();
			if (got.first !== want.first || got.second !== want.second ||
				got.count !== want.count || got.run_last !== want.run_last ||
				got.done !== want.done)
				flag("pixel mismatch", want, got);
		endfunction

		function int pending();
			return pixel_queue.size();
		endfunction

		function void flush_leftovers();
			while (pixel_queue.size() != 0)
				flag("missing pixel transfer", pixel_queue.pop_front(), '0);
		endfunction
	endclass

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               cfg_we;
	logic [pcx_rle_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pcx_rle_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                               in_valid;
	logic                               in_ready;
	logic [7:0]                         code_byte;
	logic                               out_valid;
	logic                               out_ready;
	logic [3:0]                         pixel_first;
	logic [3:0]                         pixel_second;
	logic [1:0]                         pixel_count;
	logic                               run_last;
	logic                               image_done;

	pixel_scoreboard sb;
	int unsigned     tx_idle_pct;
	int unsigned     rx_idle_pct;
	logic            rx_hold;
	int unsigned     cycle_cnt;
	event            rx_hold_start;

	pcx_rle_line_decoder_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.code_byte    (code_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_first  (pixel_first),
		.pixel_second (pixel_second),
		.pixel_count  (pixel_count),
		.run_last     (run_last),
		.image_done   (image_done)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("pcx_rle_line_decoder_top_tb: errors");
			$finish;
		end
	end

	// Long receiver stall so that the command queue fills and input backs up.
	initial begin
		rx_hold = 1'b0;
		forever begin
			@(rx_hold_start);
			rx_hold = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold = 1'b0;
		end
	end

	always @(negedge clk) begin
		if (rx_hold)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{first: pixel_first, second: pixel_second, count: pixel_count,
				run_last: run_last, done: image_done});
	end

	task automatic write_reg(input logic [pcx_rle_pkg::CFG_IDX_W-1:0] idx,
		input logic [pcx_rle_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	// Writes the line setup and, if asked, total_pixels, which restarts the image.
	task automatic apply_setup(input logic mode, input logic [15:0] bpl, input logic [15:0] lw,
		input logic [23:0] total, input bit restart);
		write_reg(pcx_rle_pkg::REG_PIXEL_MODE, {23'd0, mode});
		write_reg(pcx_rle_pkg::REG_BYTES_PER_LINE, {8'd0, bpl});
		write_reg(pcx_rle_pkg::REG_LINE_WIDTH, {8'd0, lw});
		if (restart)
			write_reg(pcx_rle_pkg::REG_TOTAL_PIXELS, total);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Returns at the rising edge where the byte transfer takes place.
	task automatic push_code(input logic [7:0] code);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		code_byte <= code;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_byte(code);
	endtask

	task automatic drain_pixels();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random_phase(input int unsigned phase);
		logic [15:0] bpl;
		logic [15:0] lw;
		logic [23:0] total;
		logic [5:0]  cnt;
		int unsigned sent;
		int unsigned pick;
		sent = 0;
		case ($urandom_range(9))
			0: bpl = 16'd0;
			1: bpl = 16'hFFFF;
			default: bpl = 16'($urandom_range(1, 8));
		endcase
		case ($urandom_range(19))
			0: lw = 16'hFFFF;
			1: lw = 16'd0;
			default: lw = 16'($urandom_range(1, 10));
		endcase
		total = (phase == RANDOM_PHASES - 1) ? 24'hFFFFFF : 24'($urandom_range(100, 3000));
		apply_setup(1'($urandom_range(1)), bpl, lw, total,
			phase == 0 || $urandom_range(3) != 0);
		if (phase == 2)
			-> rx_hold_start;
		while (sent < PHASE_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				push_code(8'($urandom_range(0, 191)));
				sent += 1;
			end else if (pick < 85) begin
				cnt = ($urandom_range(9) == 0) ? 6'($urandom_range(0, 63))
					: 6'($urandom_range(1, 6));
				push_code(pcx_rle_pkg::MARKER_MASK | {2'b00, cnt});
				push_code(8'($urandom_range(255)));
				sent += 2;
			end else begin
				push_code(8'($urandom_range(255)));
				sent += 1;
			end
		end
		drain_pixels();
	endtask

	initial begin
		sb          = new();
		cycle_cnt   = 0;
		tx_idle_pct = 15;
		rx_idle_pct = 49;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		code_byte   = '0;
		out_ready   = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Literal extremes, a short run, a zero-length run and a full 63-byte run
		// across lines with padding.
		apply_setup(1'b0, 16'd4, 16'd3, 24'd1000, 1'b1);
		push_code(8'h00); push_code(8'h3F); push_code(8'h80); push_code(8'hBF);
		push_code(8'h41); push_code(8'hC3); push_code(8'hFF); push_code(8'hC0);
		push_code(8'h12); push_code(8'hFF); push_code(8'hA5); push_code(8'h7E);
		drain_pixels();

		// Two-pixel mode with an odd total: the image ends inside a run on a
		// single-pixel transfer, and later bytes are ignored.
		apply_setup(1'b1, 16'd2, 16'd5, 24'd7, 1'b1);
		push_code(8'hC5); push_code(8'h9C); push_code(8'h11); push_code(8'hC2);
		push_code(8'h33);
		drain_pixels();

		// A zero total finishes the image at once.
		write_reg(pcx_rle_pkg::REG_TOTAL_PIXELS, 24'd0);
		@(negedge clk);
		cfg_we <= 1'b0;
		push_code(8'h5A);
		drain_pixels();

		// Widest lines and largest image, then the line is shrunk under the
		// running index, then zero lengths.
		apply_setup(1'b0, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1);
		push_code(8'h05); push_code(8'hC4); push_code(8'h66);
		drain_pixels();
		apply_setup(1'b0, 16'd2, 16'hFFFF, 24'd0, 1'b0);
		push_code(8'h21); push_code(8'h22);
		drain_pixels();
		apply_setup(1'b0, 16'd0, 16'd0, 24'd0, 1'b0);
		push_code(8'h33);
		drain_pixels();

		for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
			if (p < 2) begin
				tx_idle_pct = 15;
				rx_idle_pct = 49;
			end else if (p < 4) begin
				tx_idle_pct = 49;
				rx_idle_pct = 15;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			run_random_phase(p);
		end

		sb.flush_leftovers();
		if (sb.errors == 0)
			$display("pcx_rle_line_decoder_top_tb: clean");
		else
			$display("pcx_rle_line_decoder_top_tb: errors");
		$finish;
	end

endmodule
